[design/ohr_pkg.sv]
package ohr_pkg;

  typedef struct packed {
    logic [15:0] sample;
    logic [31:0] timestamp_ms;
  } ohr_in_t;

  typedef struct packed {
    logic [7:0]  heart_rate;
    logic        beat_active;
    logic [15:0] baseline_level;
    logic [15:0] smoothed_sample;
  } ohr_out_t;

  // front -> back work item
  typedef struct packed {
    logic        new_beat;
    logic        check_loss;
    logic [31:0] ts;
    logic        beat_active;
    logic [15:0] baseline_level;
    logic [15:0] smoothed_sample;
  } ohr_job_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_SIG_THR   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SIG_HYST  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NOISE_THR = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NEG_NOISE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AUTO_RST  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LOW_RST   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_LOSS_TO   = 3'd7;

  localparam logic [31:0] RateNum = 32'd60000;
  localparam logic [7:0]  RateMin = 8'd40;
  localparam logic [7:0]  RateMax = 8'd200;

endpackage

[design/ohr_front.sv]
module ohr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  ohr_pkg::ohr_in_t    in_i,
  input  logic [15:0]         sig_thr_i,
  input  logic [15:0]         sig_hyst_i,
  input  logic [15:0]         noise_thr_i,
  input  logic [15:0]         neg_noise_i,
  input  logic [7:0]          debounce_i,
  input  logic [7:0]          auto_rst_i,
  input  logic [7:0]          low_rst_i,
  output ohr_pkg::ohr_job_t   job_o
);
  import ohr_pkg::*;

  logic [15:0] smooth_q, base_q;
  logic        first_q, valid_q, armed_q, edge_q;
  logic [7:0]  low_ctr_q, auto_ctr_q, deb_ctr_q;

  logic [15:0] sm, base_d, diff;
  logic        first_d, valid_d, armed_d;
  logic [7:0]  low_ctr_d, auto_ctr_d, deb_ctr_d;
  logic [18:0] acc6;
  logic [39:0] prod;

  always_comb begin
    acc6 = {3'b0, smooth_q} * 19'd6 + {3'b0, in_i.sample};
    // divide by 7: multiply by ceil(2^k/7) with k=22, exact for acc < 2^19
    prod = {21'b0, acc6} * 40'd599187;
    sm = prod[37:22];
    base_d = base_q; first_d = first_q; valid_d = valid_q; armed_d = armed_q;
    low_ctr_d = low_ctr_q; auto_ctr_d = auto_ctr_q; deb_ctr_d = deb_ctr_q;
    diff = '0;
    if (first_q) begin
      base_d = sm;
      first_d = 1'b0;
    end else if (sm >= base_q) begin
      low_ctr_d = '0;
      diff = sm - base_q;
      if (diff > noise_thr_i) begin
        if (diff >= sig_thr_i || (diff >= sig_hyst_i && valid_q)) begin
          if (diff >= sig_thr_i && armed_q) begin
            deb_ctr_d = deb_ctr_q + 8'd1;
            if (deb_ctr_d >= debounce_i) begin
              valid_d = 1'b1;
              armed_d = 1'b0;
            end
          end
          auto_ctr_d = auto_ctr_q + 8'd1;
          if (auto_ctr_d >= auto_rst_i) begin
            base_d = sm;
            auto_ctr_d = '0; deb_ctr_d = '0; valid_d = 1'b0; armed_d = 1'b1;
          end
        end else begin
          auto_ctr_d = '0; deb_ctr_d = '0; valid_d = 1'b0; armed_d = 1'b1;
        end
      end else begin
        base_d = base_q + {3'b0, diff[15:3]};
        auto_ctr_d = '0; deb_ctr_d = '0; valid_d = 1'b0; armed_d = 1'b1;
      end
    end else begin
      auto_ctr_d = '0; deb_ctr_d = '0; valid_d = 1'b0; armed_d = 1'b1;
      diff = base_q - sm;
      if (diff > neg_noise_i) begin
        low_ctr_d = low_ctr_q + 8'd1;
        if (low_ctr_d >= low_rst_i) begin
          base_d = sm;
          low_ctr_d = '0;
        end
      end else begin
        base_d = base_q - {3'b0, diff[15:3]};
        low_ctr_d = '0;
      end
    end
    job_o.new_beat        = valid_d && !edge_q;
    job_o.check_loss      = !valid_d;
    job_o.ts              = in_i.timestamp_ms;
    job_o.beat_active     = valid_d;
    job_o.baseline_level  = base_d;
    job_o.smoothed_sample = sm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0; base_q <= '0; first_q <= 1'b1; valid_q <= 1'b0;
      armed_q <= 1'b1; edge_q <= 1'b0;
      low_ctr_q <= '0; auto_ctr_q <= '0; deb_ctr_q <= '0;
    end else if (go_i) begin
      smooth_q <= sm; base_q <= base_d; first_q <= first_d;
      valid_q <= valid_d; armed_q <= armed_d; edge_q <= valid_d;
      low_ctr_q <= low_ctr_d; auto_ctr_q <= auto_ctr_d; deb_ctr_q <= deb_ctr_d;
    end
  end

endmodule

[design/ohr_queue.sv]
module ohr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  ohr_pkg::ohr_job_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output ohr_pkg::ohr_job_t rdata_o,
  output logic              empty_o
);
  import ohr_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  ohr_job_t        mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o)
        wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + AW'(1);
      if (rd_i && !empty_o)
        rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr_i && !full_o) - (AW+1)'(rd_i && !empty_o);
    end
  end

endmodule

[design/ohr_back.sv]
module ohr_back #(
  parameter int unsigned WindowBeats = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  ohr_pkg::ohr_job_t  job_i,
  output logic               job_take_o,
  input  logic [15:0]        loss_to_i,
  output logic               empty_o,
  output ohr_pkg::ohr_out_t  out_o,
  input  logic               pop_i
);
  import ohr_pkg::*;

  localparam int unsigned SW = $clog2(WindowBeats);
  localparam int unsigned NW = $clog2(WindowBeats + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]    st_q;
  logic [31:0]   times_q [WindowBeats];
  logic [31:0]   rd_q;
  logic [NW-1:0] n_q;
  logic [SW-1:0] old_q;
  logic [7:0]    ha_q, hb_q, rate_q;
  logic [31:0]   last_q;
  ohr_job_t      job_q;
  logic          full_q;
  ohr_out_t      res_q;
  logic [31:0]   span_q, quo_q;
  logic [37:0]   num_q;
  logic [31:0]   rem_q;
  logic [5:0]    bit_q;

  logic [SW-1:0] wslot;
  logic [SW:0]   wsum;
  logic [32:0]   trial;
  logic [7:0]    lo, hi, med, raw;

  assign empty_o = !full_q;
  assign out_o   = res_q;
  assign job_take_o = (st_q == ST_IDLE) && job_valid_i;

  always_comb begin
    wsum  = {1'b0, old_q} + (SW+1)'(n_q - NW'(1));
    wslot = (wsum >= (SW+1)'(WindowBeats)) ? SW'(wsum - (SW+1)'(WindowBeats)) : wsum[SW-1:0];
    trial = {rem_q, num_q[37]} - {1'b0, span_q};
    raw   = quo_q[7:0];
    lo    = (ha_q < hb_q) ? ha_q : hb_q;
    hi    = (ha_q < hb_q) ? hb_q : ha_q;
    if (hi > raw) hi = raw;
    med   = (lo > hi) ? lo : hi;
  end

  // a single-entry window reads back the time written in the same cycle
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && job_valid_i && job_i.new_beat) times_q[wslot] <= job_i.ts;
    if (st_q == ST_IDLE)
      rd_q <= (job_valid_i && job_i.new_beat && wslot == old_q) ? job_i.ts : times_q[old_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; n_q <= NW'(1); old_q <= '0;
      ha_q <= '0; hb_q <= '0; rate_q <= '0; last_q <= '0; full_q <= 1'b0;
      job_q <= '0; res_q <= '0; span_q <= '0; num_q <= '0; rem_q <= '0;
      quo_q <= '0; bit_q <= '0;
    end else begin
      if (pop_i && full_q && st_q != ST_FIN) full_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            if (job_i.new_beat) st_q <= ST_RD;
            else st_q <= ST_FIN;
            if (job_i.beat_active) last_q <= job_i.ts;
          end
        end
        ST_RD: begin
          span_q <= job_q.ts - rd_q;
          st_q   <= ST_MUL;
        end
        ST_MUL: begin
          num_q <= 38'(RateNum * 32'(n_q - NW'(1)));
          rem_q <= '0; quo_q <= '0; bit_q <= 6'd38;
          st_q  <= ST_DIV;
          if (n_q < NW'(WindowBeats)) n_q <= n_q + NW'(1);
          else old_q <= (old_q == SW'(WindowBeats-1)) ? '0 : old_q + SW'(1);
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle; zero span gives 0
          if (span_q == '0) begin
            st_q <= ST_FIN;
          end else begin
            if (!trial[32]) begin
              rem_q <= trial[31:0]; quo_q <= {quo_q[30:0], 1'b1};
            end else begin
              rem_q <= {rem_q[30:0], num_q[37]}; quo_q <= {quo_q[30:0], 1'b0};
            end
            num_q <= {num_q[36:0], 1'b0};
            bit_q <= bit_q - 6'd1;
            if (bit_q <= 6'd1) st_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!full_q || pop_i) begin
            logic [7:0] r;
            r = rate_q;
            if (job_q.new_beat) begin
              r = (med < RateMin || med > RateMax) ? 8'd0 : med;
              ha_q <= hb_q; hb_q <= raw;
            end else if (job_q.check_loss && (job_q.ts - last_q) > {16'b0, loss_to_i}) begin
              ha_q <= '0; hb_q <= '0; r = '0; n_q <= NW'(1);
            end
            rate_q <= r;
            res_q.heart_rate      <= r;
            res_q.beat_active     <= job_q.beat_active;
            res_q.baseline_level  <= job_q.baseline_level;
            res_q.smoothed_sample <= job_q.smoothed_sample;
            full_q <= 1'b1;
            st_q   <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/optical_heart_rate_detector_core.sv]
// Optical heart-rate detector core.
// Input channel: push_i/full_o carry one item (sample, timestamp_ms). An item
// is taken when push_i is high and full_o low. The front stage smooths the
// sample, tracks the baseline and debounces beats in the accepting cycle,
// then hands a job to a two-entry queue.
// Result channel: empty_o/pop_i. The oldest result sits on result_o while
// empty_o is low; pop_i takes it.
// Flow: a plain sample passes through the queue and the back stage's job
// register into the result register. An item that starts a beat runs a
// 38-step serial divider in the back stage (60000*(n-1)/span), skipped when
// the span is zero; the back stage takes no new item from the queue until
// the current one has reached the result register.
// A stalled receiver holds the back stage in its finish step; the queue then
// fills and full_o rises. Beat times live in a WindowBeats-deep window that
// needs no clearing: an entry is always written before it is read.
// Reset (rst_ni low) returns registers to their defaults and control state to
// the power-on values; the window, queue entries and window read register keep their contents.
// Configuration writes via cfg_we_i/cfg_idx_i/cfg_data_i while idle.
module optical_heart_rate_detector_core #(
  parameter int unsigned WindowBeats = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  ohr_pkg::ohr_in_t              item_i,
  output logic                          full_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output ohr_pkg::ohr_out_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [ohr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ohr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ohr_pkg::*;

  logic [15:0] sig_thr_q, sig_hyst_q, noise_q, neg_noise_q, loss_q;
  logic [7:0]  deb_q, auto_q, low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_thr_q <= 16'd5000; sig_hyst_q <= 16'd4500; noise_q <= 16'd1500;
      neg_noise_q <= 16'd1500; deb_q <= 8'd10; auto_q <= 8'd150;
      low_q <= 8'd25; loss_q <= 16'd3000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIG_THR:   sig_thr_q   <= cfg_data_i;
        REG_SIG_HYST:  sig_hyst_q  <= cfg_data_i;
        REG_NOISE_THR: noise_q     <= cfg_data_i;
        REG_NEG_NOISE: neg_noise_q <= cfg_data_i;
        REG_DEBOUNCE:  deb_q       <= cfg_data_i[7:0];
        REG_AUTO_RST:  auto_q      <= cfg_data_i[7:0];
        REG_LOW_RST:   low_q       <= cfg_data_i[7:0];
        REG_LOSS_TO:   loss_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ohr_job_t fjob, qjob;
  logic     q_empty, take;
  logic     go;

  assign go = push_i && !full_o;

  ohr_front u_front (
    .clk_i, .rst_ni, .go_i(go), .in_i(item_i),
    .sig_thr_i(sig_thr_q), .sig_hyst_i(sig_hyst_q), .noise_thr_i(noise_q),
    .neg_noise_i(neg_noise_q), .debounce_i(deb_q), .auto_rst_i(auto_q),
    .low_rst_i(low_q), .job_o(fjob)
  );

  ohr_queue #(.Depth(2)) u_queue (
    .clk_i, .rst_ni, .wr_i(push_i), .wdata_i(fjob), .full_o(full_o),
    .rd_i(take), .rdata_o(qjob), .empty_o(q_empty)
  );

  ohr_back #(.WindowBeats(WindowBeats)) u_back (
    .clk_i, .rst_ni, .job_valid_i(!q_empty), .job_i(qjob), .job_take_o(take),
    .loss_to_i(loss_q), .empty_o(empty_o), .out_o(result_o), .pop_i(pop_i)
  );

endmodule

[design/ohr_checker.sv]
module ohr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push_i,
  input logic              full_o,
  input logic              empty_o,
  input logic              pop_i,
  input ohr_pkg::ohr_out_t result_o
);
  import ohr_pkg::*;

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (result_o.heart_rate == 8'd0 ||
      (result_o.heart_rate >= RateMin && result_o.heart_rate <= RateMax)))
    else $error("rate out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(result_o)))
    else $error("result changed while waiting");

  a_reset_not_full: assert property (@(posedge clk_i)
    !rst_ni |=> !full_o)
    else $error("full after reset");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> empty_o)
    else $error("not empty after reset");

endmodule

bind optical_heart_rate_detector_core ohr_checker u_ohr_checker (
  .clk_i, .rst_ni, .push_i, .full_o, .empty_o, .pop_i, .result_o
);
